/* src/matrix3_inverse_adjugate_defines.svh */
// assertion macros shared by the 3x3 inverse block
`ifndef MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH

`ifndef SYNTHESIS
`define MI3_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mi3 same-cycle check failed");
`define MI3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mi3 next-cycle check failed");
`else
`define MI3_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MI3_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* src/mi3_pkg.sv */
// shared constants of the 3x3 inverse block
package mi3_pkg;

    localparam int NUM_ELEMS   = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int TOL_WIDTH   = 31;

endpackage

/* src/mi3_front.sv */
// front pipeline: cofactors of the adjugate and the determinant
`include "matrix3_inverse_adjugate_defines.svh"

module mi3_front #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [mi3_pkg::NUM_ELEMS*ELEM_WIDTH-1:0]      in_elems,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [mi3_pkg::NUM_ELEMS*(2*ELEM_WIDTH+1)-1:0] out_adj,
    output logic [3*ELEM_WIDTH+2:0]                       out_det
);
    import mi3_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int PW   = 2*W;
    localparam int AW   = 2*W+1;
    localparam int SW   = 2*W+1;
    localparam int DW   = 3*W+3;
    localparam int NSTG = 5;

    // adj[k] = a*b - c*d, element indices in column-major order
    localparam logic [3:0] IDX_A [NUM_ELEMS] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] IDX_B [NUM_ELEMS] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] IDX_C [NUM_ELEMS] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] IDX_D [NUM_ELEMS] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    logic [NSTG-1:0]        vld_reg;
    logic                   en;
    logic signed [W-1:0]    elem [NUM_ELEMS];
    logic signed [PW-1:0]   pa_reg [NUM_ELEMS];
    logic signed [PW-1:0]   pc_reg [NUM_ELEMS];
    logic signed [W-1:0]    e1_reg [3];
    logic signed [W-1:0]    e2_reg [3];
    logic signed [AW-1:0]   adj2_reg [NUM_ELEMS];
    logic signed [AW-1:0]   adj3_reg [NUM_ELEMS];
    logic signed [AW-1:0]   adj4_reg [NUM_ELEMS];
    logic signed [AW-1:0]   adj5_reg [NUM_ELEMS];
    logic signed [SW-1:0]   plo_reg [3];
    logic signed [SW-1:0]   phi_reg [3];
    logic signed [DW-1:0]   t_reg [3];
    logic signed [DW-1:0]   det_reg;

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTG-1];
    assign out_det   = det_reg;

    always_comb begin
        for (int i = 0; i < NUM_ELEMS; i++) begin
            elem[i]             = in_elems[i*W +: W];
            out_adj[i*AW +: AW] = adj5_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_ELEMS; k++) begin
                pa_reg[k]   <= elem[IDX_A[k]] * elem[IDX_B[k]];
                pc_reg[k]   <= elem[IDX_C[k]] * elem[IDX_D[k]];
                adj2_reg[k] <= AW'(pa_reg[k]) - AW'(pc_reg[k]);
                adj3_reg[k] <= adj2_reg[k];
                adj4_reg[k] <= adj3_reg[k];
                adj5_reg[k] <= adj4_reg[k];
            end
            for (int j = 0; j < 3; j++) begin
                e1_reg[j]  <= elem[3*j];
                e2_reg[j]  <= e1_reg[j];
                // split the cofactor so each multiplier operand stays about one word wide
                plo_reg[j] <= e2_reg[j] * $signed({1'b0, adj2_reg[j][W-1:0]});
                phi_reg[j] <= e2_reg[j] * $signed(adj2_reg[j][AW-1:W]);
                t_reg[j]   <= (DW'(phi_reg[j]) <<< W) + DW'(plo_reg[j]);
            end
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    `MI3_ASSERT_NEXT(a_front_hold, aclk, aresetn, !en, $stable(vld_reg))

endmodule

/* src/mi3_queue.sv */
// short queue between the front and back pipelines
`include "matrix3_inverse_adjugate_defines.svh"

module mi3_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import mi3_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `MI3_ASSERT_NEXT(a_queue_grow, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `MI3_ASSERT_NEXT(a_queue_shrink, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

/* src/mi3_back.sv */
// back pipeline: singular test, bit-per-stage division, rounding and clipping
`include "matrix3_inverse_adjugate_defines.svh"

module mi3_back #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic [mi3_pkg::TOL_WIDTH-1:0]                  tol,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [mi3_pkg::NUM_ELEMS*(2*ELEM_WIDTH+1)-1:0] in_adj,
    input  logic [3*ELEM_WIDTH+2:0]                        in_det,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [mi3_pkg::NUM_ELEMS*ELEM_WIDTH-1:0]       out_elems,
    output logic                                           out_singular,
    output logic                                           out_saturated
);
    import mi3_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = 2*W+1;
    localparam int DW   = 3*W+3;
    localparam int RW   = AW+1;
    localparam int MW   = RW-F;
    localparam int NW   = AW+2*F;
    localparam int TW   = NW-W;
    localparam int XW   = (TW > DW) ? TW : DW;
    localparam int LW   = TOL_WIDTH+2*F;
    localparam int CW   = (LW > DW) ? LW : DW;
    localparam int NSTG = W+4;
    localparam logic [RW-1:0] HALF = RW'(1) << (F-1);

    logic [NSTG-1:0]      vld_reg;
    logic                 en;

    // absolute values
    logic [AW-1:0]        amag1_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] aneg1_reg;
    logic [DW-1:0]        dmag1_reg;
    logic                 dneg1_reg;

    // singular test and divider set-up
    logic                 sing_c;
    logic [NW-1:0]        nvec [NUM_ELEMS];
    logic [RW-1:0]        rsum [NUM_ELEMS];

    // divider stages, index 0 is the set-up stage
    logic [DW-1:0]        rem_reg [W+1][NUM_ELEMS];
    logic [W-1:0]         nb_reg  [W+1][NUM_ELEMS];
    logic [W-1:0]         q_reg   [W+1][NUM_ELEMS];
    logic [MW-1:0]        rn_reg  [W+1][NUM_ELEMS];
    logic [DW-1:0]        dm_reg  [W+1];
    logic                 sg_reg  [W+1];
    logic [NUM_ELEMS-1:0] bg_reg  [W+1];
    logic [NUM_ELEMS-1:0] ng_reg  [W+1];
    logic [DW:0]          trial   [W][NUM_ELEMS];
    logic                 ge      [W][NUM_ELEMS];
    logic [DW-1:0]        rem_next [W][NUM_ELEMS];

    // rounding and result select
    logic                 rb   [NUM_ELEMS];
    logic [W:0]           dq   [NUM_ELEMS];
    logic [MW-1:0]        mag3_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] big3_reg;
    logic [NUM_ELEMS-1:0] neg3_reg;
    logic                 sing3_reg;

    // clipping
    logic [NUM_ELEMS-1:0] neg_e;
    logic [NUM_ELEMS-1:0] over;
    logic [MW-1:0]        lim  [NUM_ELEMS];
    logic [W-1:0]         clip [NUM_ELEMS];
    logic [NUM_ELEMS*W-1:0] elems4_reg;
    logic                 sing4_reg;
    logic                 sat4_reg;

    assign en            = !vld_reg[NSTG-1] || out_ready;
    assign in_ready      = en;
    assign out_valid     = vld_reg[NSTG-1];
    assign out_elems     = elems4_reg;
    assign out_singular  = sing4_reg;
    assign out_saturated = sat4_reg;

    assign sing_c = (dmag1_reg == '0) || (CW'(dmag1_reg) < (CW'(tol) << (2*F)));

    always_comb begin
        for (int k = 0; k < NUM_ELEMS; k++) begin
            nvec[k] = {amag1_reg[k], {(2*F){1'b0}}};
            rsum[k] = {1'b0, amag1_reg[k]} + HALF;
        end
        for (int s = 0; s < W; s++) begin
            for (int k = 0; k < NUM_ELEMS; k++) begin
                trial[s][k]    = {rem_reg[s][k], nb_reg[s][k][W-1]};
                ge[s][k]       = trial[s][k] >= {1'b0, dm_reg[s]};
                rem_next[s][k] = ge[s][k] ? DW'(trial[s][k] - {1'b0, dm_reg[s]})
                                          : DW'(trial[s][k]);
            end
        end
        for (int k = 0; k < NUM_ELEMS; k++) begin
            rb[k]    = {rem_reg[W][k], 1'b0} >= {1'b0, dm_reg[W]};
            dq[k]    = {1'b0, q_reg[W][k]} + (W+1)'(rb[k]);
            neg_e[k] = neg3_reg[k] && (big3_reg[k] || (mag3_reg[k] != '0));
            lim[k]   = (MW'(1) << (W-1)) - MW'(!neg_e[k]);
            over[k]  = big3_reg[k] || (mag3_reg[k] > lim[k]);
            clip[k]  = over[k] ? lim[k][W-1:0] : mag3_reg[k][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // magnitudes and signs
            for (int k = 0; k < NUM_ELEMS; k++) begin
                aneg1_reg[k] <= in_adj[k*AW+AW-1];
                amag1_reg[k] <= in_adj[k*AW+AW-1] ? (~in_adj[k*AW +: AW] + 1'b1)
                                                  : in_adj[k*AW +: AW];
            end
            dneg1_reg <= in_det[DW-1];
            dmag1_reg <= in_det[DW-1] ? (~in_det + 1'b1) : in_det;

            // singular decision, rounded adjugate, divider seed
            dm_reg[0] <= dmag1_reg;
            sg_reg[0] <= sing_c;
            for (int k = 0; k < NUM_ELEMS; k++) begin
                rn_reg[0][k]  <= rsum[k][RW-1:F];
                ng_reg[0][k]  <= sing_c ? aneg1_reg[k] : (aneg1_reg[k] ^ dneg1_reg);
                bg_reg[0][k]  <= XW'(nvec[k][NW-1:W]) >= XW'(dmag1_reg);
                rem_reg[0][k] <= DW'(nvec[k][NW-1:W]);
                nb_reg[0][k]  <= nvec[k][W-1:0];
                q_reg[0][k]   <= '0;
            end

            // one quotient bit per stage
            for (int s = 0; s < W; s++) begin
                dm_reg[s+1] <= dm_reg[s];
                sg_reg[s+1] <= sg_reg[s];
                bg_reg[s+1] <= bg_reg[s];
                ng_reg[s+1] <= ng_reg[s];
                for (int k = 0; k < NUM_ELEMS; k++) begin
                    rem_reg[s+1][k] <= rem_next[s][k];
                    nb_reg[s+1][k]  <= nb_reg[s][k] << 1;
                    q_reg[s+1][k]   <= {q_reg[s][k][W-2:0], ge[s][k]};
                    rn_reg[s+1][k]  <= rn_reg[s][k];
                end
            end

            // round to nearest and pick the path
            sing3_reg <= sg_reg[W];
            neg3_reg  <= ng_reg[W];
            for (int k = 0; k < NUM_ELEMS; k++) begin
                mag3_reg[k] <= sg_reg[W] ? rn_reg[W][k] : MW'(dq[k]);
                big3_reg[k] <= !sg_reg[W] && bg_reg[W][k];
            end

            // clip and apply sign
            sing4_reg <= sing3_reg;
            sat4_reg  <= |over;
            for (int k = 0; k < NUM_ELEMS; k++) begin
                elems4_reg[k*W +: W] <= neg_e[k] ? (~clip[k] + 1'b1) : clip[k];
            end
        end
    end

    `MI3_ASSERT_NEXT(a_back_hold, aclk, aresetn, !en, $stable(vld_reg))
    `MI3_ASSERT_IMPL(a_back_pop, aclk, aresetn, in_valid && !vld_reg[NSTG-1], in_ready)

endmodule

/* src/matrix3_inverse_adjugate.sv */
// top level of the 3x3 matrix inverse by the adjugate method
//
// usage:
// - s_ channel: one word per matrix, nine signed fixed-point elements in
//   column-major order; a word is taken when s_tvalid and s_tready are high
// - m_ channel: one word per matrix with the nine result elements and two
//   flags in m_tuser (singular, saturated)
// - cfg channel: writes the singular tolerance; always ready, write it only
//   while no matrix is in flight
// - throughput is one matrix per cycle while the receiver takes results; a
//   matrix passes 5 front stages, the queue and ELEM_WIDTH+4 back stages,
//   where the divider resolves one quotient bit per pipeline stage
// - a stalled receiver holds m_tdata; the back pipeline freezes, the queue
//   fills and then the front pipeline and s_tready stop
// - reset empties both pipelines and the queue and sets the tolerance to 1
module matrix3_inverse_adjugate #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int TDATA_W   = ((mi3_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // col0_row0, col0_row1, col0_row2, col1_row0 .. col2_row2
    input  logic [TDATA_W-1:0]            s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0 .. inv_c2_r2
    output logic [TDATA_W-1:0]            m_tdata,
    // singular, saturated
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mi3_pkg::TOL_WIDTH-1:0] cfg_data
);
    import mi3_pkg::*;

    localparam int AW = 2*ELEM_WIDTH+1;
    localparam int DW = 3*ELEM_WIDTH+3;
    localparam int QW = NUM_ELEMS*AW + DW;

    logic [TOL_WIDTH-1:0]            tol_reg;

    // front to queue
    logic                            f_valid, f_ready;
    logic [NUM_ELEMS*AW-1:0]         f_adj;
    logic [DW-1:0]                   f_det;

    // queue to back
    logic                            q_valid, q_ready;
    logic [QW-1:0]                   q_data;

    logic [NUM_ELEMS*ELEM_WIDTH-1:0] res_elems;
    logic                            res_singular, res_saturated;

    assign cfg_ready = 1'b1;

    // tolerance register, reset to one lsb
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_WIDTH'(1);
        end else if (cfg_valid && cfg_ready) begin
            tol_reg <= cfg_data;
        end
    end

    // cofactors and determinant, exact
    mi3_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_elems  (s_tdata[NUM_ELEMS*ELEM_WIDTH-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_adj   (f_adj),
        .out_det   (f_det)
    );

    // decouples the two pipelines so each stalls on its own
    mi3_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_det, f_adj}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // singular test, division, rounding, clipping; ends in the output register
    mi3_back #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tol           (tol_reg),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_adj        (q_data[NUM_ELEMS*AW-1:0]),
        .in_det        (q_data[QW-1:NUM_ELEMS*AW]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_elems     (res_elems),
        .out_singular  (res_singular),
        .out_saturated (res_saturated)
    );

    assign m_tdata = TDATA_W'(res_elems);
    assign m_tuser = {res_saturated, res_singular};

endmodule
